// ----- src/scc_pkg.sv -----
package scc_pkg;

	localparam int ENTRIES_DEF = 64;
	localparam int MAX_RESULTS = 64;
	localparam int SLOT_W      = 6;
	localparam int SECTOR_W    = 32;
	localparam int FCNT_W      = $clog2(MAX_RESULTS) + 1;

	typedef enum logic [1:0] {
		MODE_READ  = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_FLUSH = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_SWEEP,
		ST_VREAD,
		ST_FLUSH,
		ST_FDONE
	} state_t;

	typedef struct packed {
		logic [SLOT_W-1:0]   slot;
		logic                hit;
		logic                fill_needed;
		logic                writeback_needed;
		logic [SECTOR_W-1:0] writeback_sector;
		logic                last;
	} result_t;

endpackage

// ----- src/scc_ram.sv -----
module scc_ram
	import scc_pkg::*;
#(
	parameter int WIDTH = SECTOR_W,
	parameter int DEPTH = ENTRIES_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- src/scc_ctrl.sv -----
module scc_ctrl
	import scc_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [1:0]                 mode,
	input  logic [SECTOR_W-1:0]        sector,
	output logic                       busy,
	output logic                       ram_we,
	output logic [$clog2(ENTRIES)-1:0] ram_waddr,
	output logic [SECTOR_W-1:0]        ram_wdata,
	output logic [$clog2(ENTRIES)-1:0] ram_raddr,
	input  logic [SECTOR_W-1:0]        ram_rdata,
	output logic                       res_vld,
	output result_t                    res
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);

	function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
		logic [IDX_W+SLOT_W-1:0] ext;
		ext = {{SLOT_W{1'b0}}, idx};
		return ext[SLOT_W-1:0];
	endfunction

	state_t              state_q, state_d;
	mode_t               mode_q;
	logic [SECTOR_W-1:0] sector_q;
	logic [CNT_W-1:0]    scan_q;
	logic                rd_vld_s1;
	logic [IDX_W-1:0]    rd_idx_s1;
	logic [IDX_W-1:0]    ptr_q;
	logic [IDX_W-1:0]    victim_q;
	logic [ENTRIES-1:0]  valid_q, dirty_q, acc_q;
	logic                pend_vld_q;
	result_t             pend_q;
	logic [FCNT_W-1:0]   fcnt_q;
	logic                out_vld_q;
	result_t             out_q;

	// Conditions shared by the next-state and output logic.
	logic scan_more, entry_valid, entry_dirty, tag_match, last_idx;
	logic lk_hit, lk_free, lk_full, fl_dirty, fl_cap, fl_end, sw_victim;

	assign scan_more   = scan_q != CNT_W'(ENTRIES);
	assign entry_valid = valid_q[rd_idx_s1];
	assign entry_dirty = dirty_q[rd_idx_s1];
	assign tag_match   = ram_rdata == sector_q;
	assign last_idx    = rd_idx_s1 == IDX_W'(ENTRIES - 1);
	assign lk_hit      = rd_vld_s1 && entry_valid && tag_match;
	// Slots are only ever filled lowest-invalid first and never invalidated, so the
	// valid slots form a prefix: the first invalid slot ends the search.
	assign lk_free     = rd_vld_s1 && !entry_valid;
	assign lk_full     = rd_vld_s1 && entry_valid && !tag_match && last_idx;
	assign fl_dirty    = rd_vld_s1 && entry_valid && entry_dirty;
	assign fl_cap      = fl_dirty && (fcnt_q == FCNT_W'(MAX_RESULTS - 1));
	assign fl_end      = rd_vld_s1 && last_idx;
	assign sw_victim   = !acc_q[ptr_q];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (mode_t'(mode)) inside
						MODE_READ, MODE_WRITE: state_d = ST_LOOKUP;
						MODE_FLUSH:            state_d = ST_FLUSH;
						default:               state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOOKUP: begin
				if (lk_hit || lk_free) begin
					state_d = ST_IDLE;
				end else if (lk_full) begin
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (sw_victim) begin
					state_d = ST_VREAD;
				end
			end
			ST_VREAD: state_d = ST_IDLE;
			ST_FLUSH: begin
				if (fl_cap || fl_end) begin
					state_d = ST_FDONE;
				end
			end
			ST_FDONE: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	logic             issue, take, hit_upd, clr_acc, fl_take, emit;
	logic [IDX_W-1:0] take_idx;
	result_t          emit_res;
	result_t          miss_res;
	logic             victim_dirty;

	assign victim_dirty = dirty_q[victim_q];

	always_comb begin
		miss_res                  = '0;
		miss_res.fill_needed      = mode_q == MODE_READ;
		miss_res.last             = 1'b1;
		issue                     = 1'b0;
		take                      = 1'b0;
		take_idx                  = rd_idx_s1;
		hit_upd                   = 1'b0;
		clr_acc                   = 1'b0;
		fl_take                   = 1'b0;
		emit                      = 1'b0;
		emit_res                  = '0;
		ram_raddr                 = scan_q[IDX_W-1:0];
		unique case (state_q)
			ST_LOOKUP: begin
				issue = scan_more;
				if (lk_hit) begin
					hit_upd       = 1'b1;
					emit          = 1'b1;
					emit_res.slot = slot_of(rd_idx_s1);
					emit_res.hit  = 1'b1;
					emit_res.last = 1'b1;
				end else if (lk_free) begin
					take          = 1'b1;
					emit          = 1'b1;
					emit_res      = miss_res;
					emit_res.slot = slot_of(rd_idx_s1);
				end
			end
			ST_SWEEP: begin
				ram_raddr = ptr_q;
				clr_acc   = !sw_victim;
			end
			ST_VREAD: begin
				take                      = 1'b1;
				take_idx                  = victim_q;
				emit                      = 1'b1;
				emit_res                  = miss_res;
				emit_res.slot             = slot_of(victim_q);
				emit_res.writeback_needed = victim_dirty;
				emit_res.writeback_sector = victim_dirty ? ram_rdata : '0;
			end
			ST_FLUSH: begin
				issue = scan_more;
				if (fl_dirty) begin
					fl_take  = 1'b1;
					emit     = pend_vld_q;
					emit_res = pend_q;
				end
			end
			ST_FDONE: begin
				emit          = pend_vld_q;
				emit_res      = pend_q;
				emit_res.last = 1'b1;
			end
			default: ;
		endcase
	end

	assign ram_we    = take;
	assign ram_waddr = take_idx;
	assign ram_wdata = sector_q;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rd_vld_s1  <= 1'b0;
			ptr_q      <= '0;
			valid_q    <= '0;
			dirty_q    <= '0;
			acc_q      <= '0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue && (state_d == state_q);
			out_vld_q <= emit;
			if (state_q == ST_IDLE && start) begin
				pend_vld_q <= 1'b0;
			end
			if (hit_upd) begin
				acc_q[rd_idx_s1] <= 1'b1;
				if (mode_q == MODE_WRITE) begin
					dirty_q[rd_idx_s1] <= 1'b1;
				end
			end
			if (take) begin
				valid_q[take_idx] <= 1'b1;
				acc_q[take_idx]   <= 1'b1;
				dirty_q[take_idx] <= mode_q == MODE_WRITE;
			end
			if (state_q == ST_SWEEP) begin
				ptr_q <= (ptr_q == IDX_W'(ENTRIES - 1)) ? '0 : ptr_q + 1'b1;
			end
			if (clr_acc) begin
				acc_q[ptr_q] <= 1'b0;
			end
			if (fl_take) begin
				dirty_q[rd_idx_s1] <= 1'b0;
				pend_vld_q         <= 1'b1;
			end
			if (state_q == ST_FDONE) begin
				pend_vld_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_q[IDX_W-1:0];
		if (state_q == ST_IDLE && start) begin
			mode_q   <= mode_t'(mode);
			sector_q <= sector;
			scan_q   <= '0;
			fcnt_q   <= '0;
		end
		if (issue) begin
			scan_q <= scan_q + 1'b1;
		end
		if (state_q == ST_SWEEP && sw_victim) begin
			victim_q <= ptr_q;
		end
		if (fl_take) begin
			fcnt_q                  <= fcnt_q + 1'b1;
			pend_q.slot             <= slot_of(rd_idx_s1);
			pend_q.hit              <= 1'b0;
			pend_q.fill_needed      <= 1'b0;
			pend_q.writeback_needed <= 1'b1;
			pend_q.writeback_sector <= ram_rdata;
			pend_q.last             <= 1'b0;
		end
		if (emit) begin
			out_q <= emit_res;
		end
	end

	assign busy    = state_q != ST_IDLE;
	assign res_vld = out_vld_q;
	assign res     = out_q;

	a_sweep_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SWEEP |-> &valid_q)
		else $error("clock sweep entered with an invalid slot present");

	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q & (valid_q + 1'b1)) == '0)
		else $error("valid slots do not form a prefix");

	a_victim_unaccessed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_VREAD |-> !acc_q[victim_q])
		else $error("victim slot still has its accessed bit set");

	a_hit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_q.hit |-> !out_q.writeback_needed && !out_q.fill_needed)
		else $error("hit result asks for fill or write-back");

endmodule

// ----- src/sector_cache_clock_replacement.sv -----
// Tag and replacement controller for a fully associative sector cache with
// clock (second chance) replacement. Data bytes live elsewhere.
// A command transaction is taken at a rising edge with start high and busy low:
// mode selects read, write or flush, and sector names the disk sector.
// Results appear for exactly one cycle each, marked by valid; the receiver must
// take every result as it comes, since it cannot hold the block off.
// A read or write gives one result. The tag RAM is searched one slot per cycle
// through its registered read port by a single shared comparator. The search
// stops at a hit or at the first free slot, which a miss then takes. With every
// slot valid, the search covers all ENTRIES slots, then the clock sweep visits
// one slot per cycle, clearing accessed bits, until it meets a slot whose
// accessed bit is clear; that victim's tag is read before the result goes out.
// A flush scans all slots and emits one result per dirty slot in ascending
// order, the final one flagged by last; at most 64.
// A new command can be taken the cycle after the final result is registered.
// Reset clears the valid, dirty and accessed bits and the clock pointer at once;
// the tag RAM is not cleared and needs no clearing pass.
module sector_cache_clock_replacement
	import scc_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          mode,
	input  logic [SECTOR_W-1:0] sector,
	output logic                valid,
	output logic [SLOT_W-1:0]   slot,
	output logic                hit,
	output logic                fill_needed,
	output logic                writeback_needed,
	output logic [SECTOR_W-1:0] writeback_sector,
	output logic                last
);

	localparam int IDX_W = $clog2(ENTRIES);

	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	logic [SECTOR_W-1:0] ram_wdata;
	logic [IDX_W-1:0]    ram_raddr;
	logic [SECTOR_W-1:0] ram_rdata;
	result_t             res;

	// Tag store: one sector number per slot.
	scc_ram #(
		.WIDTH(SECTOR_W),
		.DEPTH(ENTRIES)
	) u_tags (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Sequencer with the shared tag comparator and the per-slot status bits.
	scc_ctrl #(
		.ENTRIES(ENTRIES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.mode     (mode),
		.sector   (sector),
		.busy     (busy),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.res_vld  (valid),
		.res      (res)
	);

	// Each result field goes out on a port of its own.
	assign slot             = res.slot;
	assign hit              = res.hit;
	assign fill_needed      = res.fill_needed;
	assign writeback_needed = res.writeback_needed;
	assign writeback_sector = res.writeback_sector;
	assign last             = res.last;

endmodule

// ----- bench/tb_sector_cache_clock_replacement.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the clock second-chance sector cache controller.
// Commands go in through the start/busy handshake. A cycle-free model of the tag
// store and the replacement policy runs alongside and queues the results that
// each accepted transaction should produce. A monitor takes every result strobe
// and compares it field by field with the oldest queued result.
module tb_sector_cache_clock_replacement;
	import scc_pkg::*;

	localparam int          ENTRIES       = ENTRIES_DEF;
	localparam int          CLK_HALF      = 6;
	localparam int          CYCLE_LIMIT   = 1000000;
	localparam int          RANDOM_ITEMS  = 445;
	localparam int          POOL_SIZE     = 100;
	localparam int          REPORT_LIMIT  = 10;
	// The encoding that the block must ignore. It has no name in the package.
	localparam logic [1:0]  MODE_UNUSED   = 2'd3;
	// A full search plus a full sweep, the victim read and some margin.
	localparam int          DRAIN_CYCLES  = 2 * ENTRIES + 16;

	typedef struct {
		logic [1:0]          mode;
		logic [SECTOR_W-1:0] sector;
		int                  n_typed;  // -1: take the results from the cache model
		result_t             typed;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [1:0]          mode = MODE_READ;
	logic [SECTOR_W-1:0] sector = '0;
	logic                busy;
	logic                valid;
	logic [SLOT_W-1:0]   slot;
	logic                hit;
	logic                fill_needed;
	logic                writeback_needed;
	logic [SECTOR_W-1:0] writeback_sector;
	logic                last;

	sector_cache_clock_replacement #(
		.ENTRIES(ENTRIES)
	) dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.mode             (mode),
		.sector           (sector),
		.valid            (valid),
		.slot             (slot),
		.hit              (hit),
		.fill_needed      (fill_needed),
		.writeback_needed (writeback_needed),
		.writeback_sector (writeback_sector),
		.last             (last)
	);

	initial begin
		forever begin
			#CLK_HALF clk = ~clk;
		end
	end

	// Shadow copy of the cache bookkeeping. Tags are only ever read while the
	// slot is valid, so their initial contents do not matter.
	logic [SECTOR_W-1:0] cache_tag      [ENTRIES];
	logic                cache_valid    [ENTRIES];
	logic                cache_dirty    [ENTRIES];
	logic                cache_accessed [ENTRIES];
	int                  sweep_slot;

	// Results of the transaction most recently handed to the cache model.
	result_t             burst_results [MAX_RESULTS];
	int                  burst_count;

	// Results still owed by the block, oldest first.
	result_t             owed_results [$];

	int                  error_count = 0;
	int                  cycle_count = 0;

	stim_row_t           directed_rows [$];
	logic [SECTOR_W-1:0] sector_pool [POOL_SIZE];

	// Works out what one command does to the cache and which results it gives.
	task automatic predict_cache_command(input logic [1:0] cmd, input logic [SECTOR_W-1:0] sec);
		int i;
		int found;
		int victim;
		int top_dirty;
		int seen;
		logic                victim_dirty;
		logic [SECTOR_W-1:0] victim_tag;
		begin
			burst_count = 0;
			if (cmd == MODE_FLUSH) begin
				// Find the final slot that will be cleaned so that it can carry last.
				top_dirty = -1;
				seen = 0;
				for (i = 0; i < ENTRIES && seen < MAX_RESULTS; i++) begin
					if (cache_valid[i] && cache_dirty[i]) begin
						top_dirty = i;
						seen++;
					end
				end
				for (i = 0; i <= top_dirty; i++) begin
					if (cache_valid[i] && cache_dirty[i]) begin
						burst_results[burst_count] = result_t'{SLOT_W'(i), 1'b0, 1'b0, 1'b1,
							cache_tag[i], (i == top_dirty)};
						cache_dirty[i] = 1'b0;
						burst_count++;
					end
				end
			end else if (cmd == MODE_READ || cmd == MODE_WRITE) begin
				found = -1;
				for (i = 0; i < ENTRIES && found < 0; i++) begin
					if (cache_valid[i] && cache_tag[i] == sec) begin
						found = i;
					end
				end
				if (found >= 0) begin
					cache_accessed[found] = 1'b1;
					if (cmd == MODE_WRITE) begin
						cache_dirty[found] = 1'b1;
					end
					burst_results[0] = result_t'{SLOT_W'(found), 1'b1, 1'b0, 1'b0, '0, 1'b1};
				end else begin
					victim = -1;
					victim_dirty = 1'b0;
					victim_tag = '0;
					for (i = 0; i < ENTRIES && victim < 0; i++) begin
						if (!cache_valid[i]) begin
							victim = i;
						end
					end
					// No free slot: second-chance sweep from the hand. Slots that
					// were used recently lose their accessed bit and are skipped.
					while (victim < 0) begin
						i = sweep_slot;
						sweep_slot = (sweep_slot + 1 >= ENTRIES) ? 0 : sweep_slot + 1;
						if (!cache_accessed[i]) begin
							victim = i;
							if (cache_dirty[i]) begin
								victim_dirty = 1'b1;
								victim_tag = cache_tag[i];
							end
						end else begin
							cache_accessed[i] = 1'b0;
						end
					end
					cache_tag[victim] = sec;
					cache_valid[victim] = 1'b1;
					cache_accessed[victim] = 1'b1;
					cache_dirty[victim] = (cmd == MODE_WRITE);
					burst_results[0] = result_t'{SLOT_W'(victim), 1'b0, (cmd == MODE_READ),
						victim_dirty, victim_tag, 1'b1};
				end
				burst_count = 1;
			end
			// The unused encoding leaves everything alone and gives nothing.
		end
	endtask

	// Hands one command transaction to the block, after an optional idle gap.
	// The call returns in the time step of the edge that accepted the command,
	// so the next call may keep start high without lowering it in between.
	task automatic issue_command(input logic [1:0] cmd, input logic [SECTOR_W-1:0] sec,
			input int idle_pct, input int n_typed, input result_t typed);
		int gap;
		int k;
		begin
			gap = 0;
			if ($urandom_range(0, 99) < idle_pct) begin
				// Mostly short gaps, now and then one long enough to span a sweep.
				gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150)
					: $urandom_range(1, 6);
			end
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			start <= 1'b1;
			mode <= cmd;
			sector <= sec;
			// busy is read before the edge updates it, so the edge that ends this
			// loop is the one at which the block takes the transaction.
			do begin
				@(posedge clk);
			end while (busy);
			predict_cache_command(cmd, sec);
			if (n_typed < 0) begin
				for (k = 0; k < burst_count; k++) begin
					owed_results.push_back(burst_results[k]);
				end
			end else if (n_typed > 0) begin
				owed_results.push_back(typed);
			end
		end
	endtask

	function automatic stim_row_t make_row(input logic [1:0] cmd, input logic [SECTOR_W-1:0] sec,
			input int n_typed, input int exp_slot, input logic exp_hit, input logic exp_fill,
			input logic exp_wb, input logic [SECTOR_W-1:0] exp_wb_sector);
		stim_row_t row;
		begin
			row.mode = cmd;
			row.sector = sec;
			row.n_typed = n_typed;
			row.typed = result_t'{SLOT_W'(exp_slot), exp_hit, exp_fill, exp_wb, exp_wb_sector,
				1'b1};
			return row;
		end
	endfunction

	// A cycle counter guards against a block that hangs or drops results.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycle_count,
				owed_results.size());
			$display("FAIL");
			$finish;
		end
	end

	// Result monitor. Outputs are read before the edge updates them, which is the
	// value held during the cycle that this edge ends.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && valid) begin
			got = result_t'{slot, hit, fill_needed, writeback_needed, writeback_sector, last};
			if (owed_results.size() == 0) begin
				if (error_count < REPORT_LIMIT) begin
					$display("unexpected result: slot %0d hit %0b fill %0b wb %0b sector %h last %0b",
						got.slot, got.hit, got.fill_needed, got.writeback_needed,
						got.writeback_sector, got.last);
				end
				error_count <= error_count + 1;
			end else begin
				want = owed_results.pop_front();
				if (got.slot !== want.slot || got.hit !== want.hit
						|| got.fill_needed !== want.fill_needed
						|| got.writeback_needed !== want.writeback_needed
						|| got.writeback_sector !== want.writeback_sector
						|| got.last !== want.last) begin
					if (error_count < REPORT_LIMIT) begin
						$display("mismatch at cycle %0d: expected slot %0d hit %0b fill %0b wb %0b sector %h last %0b",
							cycle_count, want.slot, want.hit, want.fill_needed,
							want.writeback_needed, want.writeback_sector, want.last);
						$display("                      got slot %0d hit %0b fill %0b wb %0b sector %h last %0b",
							got.slot, got.hit, got.fill_needed, got.writeback_needed,
							got.writeback_sector, got.last);
					end
					error_count <= error_count + 1;
				end
			end
		end
	end

	initial begin
		int i;
		int phase;
		int pick;
		int done_items;
		logic [1:0]          cmd;
		logic [SECTOR_W-1:0] sec;
		int                  idle_by_phase [3];

		// After reset nothing is valid, dirty or accessed and the hand is at slot 0.
		for (i = 0; i < ENTRIES; i++) begin
			cache_tag[i] = '0;
			cache_valid[i] = 1'b0;
			cache_dirty[i] = 1'b0;
			cache_accessed[i] = 1'b0;
		end
		sweep_slot = 0;

		// Directed part. Rows with a typed result follow by hand from an empty
		// cache: free slots fill from the bottom, and a write miss asks no fill.
		directed_rows.push_back(make_row(MODE_READ,  32'h0000_0000,  1, 0, 1'b0, 1'b1, 1'b0, '0));
		directed_rows.push_back(make_row(MODE_READ,  32'hFFFF_FFFF,  1, 1, 1'b0, 1'b1, 1'b0, '0));
		directed_rows.push_back(make_row(MODE_WRITE, 32'hFFFF_FFFF,  1, 1, 1'b1, 1'b0, 1'b0, '0));
		directed_rows.push_back(make_row(MODE_READ,  32'h0000_0000,  1, 0, 1'b1, 1'b0, 1'b0, '0));
		// Only slot 1 is dirty, so the flush gives exactly one write-back.
		directed_rows.push_back(make_row(MODE_FLUSH, 32'h0000_0000,  1, 1, 1'b0, 1'b0, 1'b1,
			32'hFFFF_FFFF));
		// A flush with nothing dirty and the unused mode both give no result.
		directed_rows.push_back(make_row(MODE_FLUSH, 32'hFFFF_FFFF,  0, 0, 1'b0, 1'b0, 1'b0, '0));
		directed_rows.push_back(make_row(MODE_UNUSED, 32'h0000_0005, 0, 0, 1'b0, 1'b0, 1'b0, '0));
		directed_rows.push_back(make_row(MODE_WRITE, 32'h8000_0000,  1, 2, 1'b0, 1'b0, 1'b0, '0));
		directed_rows.push_back(make_row(MODE_WRITE, 32'h7FFF_FFFF,  1, 3, 1'b0, 1'b0, 1'b0, '0));
		directed_rows.push_back(make_row(MODE_WRITE, 32'h5555_5555,  1, 4, 1'b0, 1'b0, 1'b0, '0));
		directed_rows.push_back(make_row(MODE_WRITE, 32'hAAAA_AAAA,  1, 5, 1'b0, 1'b0, 1'b0, '0));
		directed_rows.push_back(make_row(MODE_FLUSH, 32'h0000_0000, -1, 0, 1'b0, 1'b0, 1'b0, '0));
		directed_rows.push_back(make_row(MODE_UNUSED, 32'hFFFF_FFFF, 0, 0, 1'b0, 1'b0, 1'b0, '0));
		directed_rows.push_back(make_row(MODE_WRITE, 32'h8000_0000, -1, 0, 1'b0, 1'b0, 1'b0, '0));
		directed_rows.push_back(make_row(MODE_WRITE, 32'h0000_0000, -1, 0, 1'b0, 1'b0, 1'b0, '0));
		directed_rows.push_back(make_row(MODE_READ,  32'h1234_5678, -1, 0, 1'b0, 1'b0, 1'b0, '0));
		directed_rows.push_back(make_row(MODE_FLUSH, 32'h0000_0000, -1, 0, 1'b0, 1'b0, 1'b0, '0));

		// The pool is larger than the cache, so once it fills up the sweep picks
		// victims, while reuse keeps hits and second chances frequent.
		sector_pool[0] = 32'h0000_0000;
		sector_pool[1] = 32'hFFFF_FFFF;
		sector_pool[2] = 32'h8000_0000;
		sector_pool[3] = 32'h7FFF_FFFF;
		for (i = 4; i < POOL_SIZE; i++) begin
			sector_pool[i] = $urandom;
		end

		// Sender idle percentage in each random phase.
		idle_by_phase[0] = 0;
		idle_by_phase[1] = 60;
		idle_by_phase[2] = 13;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < directed_rows.size(); i++) begin
			issue_command(directed_rows[i].mode, directed_rows[i].sector, 0,
				directed_rows[i].n_typed, directed_rows[i].typed);
		end

		// Random part: mostly reads and writes to pool sectors, some fresh
		// sectors, occasional flushes and now and then the ignored encoding.
		done_items = 0;
		while (done_items < RANDOM_ITEMS) begin
			phase = (done_items * 3) / RANDOM_ITEMS;
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				cmd = MODE_UNUSED;
				sec = $urandom;
			end else if (pick < 10) begin
				cmd = MODE_FLUSH;
				sec = $urandom;
				done_items++;
			end else begin
				cmd = ($urandom_range(0, 1) == 0) ? MODE_READ : MODE_WRITE;
				sec = ($urandom_range(0, 99) < 85) ? sector_pool[$urandom_range(0, POOL_SIZE - 1)]
					: $urandom;
				done_items++;
			end
			issue_command(cmd, sec, idle_by_phase[phase], -1, result_t'('0));
		end
		start <= 1'b0;

		// Let every owed result arrive, then watch a while longer for strays.
		while (owed_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0 && owed_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
src/scc_pkg.sv
src/scc_ram.sv
src/scc_ctrl.sv
src/sector_cache_clock_replacement.sv
bench/tb_sector_cache_clock_replacement.sv
